// File: rtl/rtp_pkg.sv
// Shared constants, types and the arctangent table for the rectangular/polar converter.
package rtp_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STEPS    = 28;
    localparam int ZFRAC           = 24;
    localparam int VEC_WIDTH       = 64;
    localparam int ZW              = 34;
    localparam int INVK_WIDTH      = 30;
    localparam logic [INVK_WIDTH-1:0] INVK_Q30 = 30'd652032874;
    localparam int FIFO_DEPTH      = 4;
    localparam int DEG90_INT       = 90;
    localparam int DEG180_INT      = 180;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    typedef struct packed {
        logic [1:0] quad;
        logic       ax_zero;
        logic       ay_zero;
    } t_cls;

    // atan(2^-i) in 2^-24 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115,
        34'sd57,        34'sd29,        34'sd14,        34'sd7
    };

endpackage

// File: rtl/rtp_front.sv
// Front end: takes a sample, folds it to the first quadrant and classifies it.
module rtp_front #(
    parameter int SAMPLE_WIDTH = rtp_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_real_in,
    input  logic signed [SAMPLE_WIDTH-1:0] i_imag_in,
    input  logic                           i_full,
    output logic                           o_push,
    output logic [SAMPLE_WIDTH-1:0]        o_ax,
    output logic [SAMPLE_WIDTH-1:0]        o_ay,
    output rtp_pkg::t_cls                  o_cls
);

    logic                    r_v;
    logic [SAMPLE_WIDTH-1:0] r_ax;
    logic [SAMPLE_WIDTH-1:0] r_ay;
    rtp_pkg::t_cls           r_cls;
    rtp_pkg::t_cls           n_cls;
    logic [SAMPLE_WIDTH-1:0] n_ax;
    logic [SAMPLE_WIDTH-1:0] n_ay;
    logic                    accept;

    assign o_stall = r_v && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_v && !i_full;

    always_comb begin
        n_ax = i_real_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_real_in) : i_real_in;
        n_ay = i_imag_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_imag_in) : i_imag_in;
        n_cls.ax_zero = (i_real_in == '0);
        n_cls.ay_zero = (i_imag_in == '0);
        if (!i_real_in[SAMPLE_WIDTH-1] && !i_imag_in[SAMPLE_WIDTH-1]) begin
            n_cls.quad = rtp_pkg::QUAD_FIRST;
        end else if (i_real_in[SAMPLE_WIDTH-1] && !i_imag_in[SAMPLE_WIDTH-1]) begin
            n_cls.quad = rtp_pkg::QUAD_SECOND;
        end else if (i_real_in[SAMPLE_WIDTH-1]) begin
            n_cls.quad = rtp_pkg::QUAD_THIRD;
        end else begin
            n_cls.quad = rtp_pkg::QUAD_FOURTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_cls <= n_cls;
        end
    end

    assign o_ax  = r_ax;
    assign o_ay  = r_ay;
    assign o_cls = r_cls;

endmodule

// File: rtl/rtp_fifo.sv
// Short register queue between the front end and the back end.
module rtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rtp_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr;
    logic [PTRW-1:0]  r_rd;
    logic [CNTW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/rtp_back.sv
// Back end: square root, vectoring CORDIC, angle mapping and rotation CORDIC pipeline.
module rtp_back #(
    parameter int SAMPLE_WIDTH    = rtp_pkg::SAMPLE_WIDTH,
    parameter int ANGLE_FRAC_BITS = rtp_pkg::ANGLE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fifo_valid,
    output logic                                o_fifo_pop,
    input  logic [SAMPLE_WIDTH-1:0]             i_ax,
    input  logic [SAMPLE_WIDTH-1:0]             i_ay,
    input  rtp_pkg::t_cls                       i_cls,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [SAMPLE_WIDTH-1:0]             o_magnitude,
    output logic signed [8+ANGLE_FRAC_BITS:0]   o_angle_deg,
    output logic [1:0]                          o_quadrant,
    output logic signed [SAMPLE_WIDTH-1:0]      o_real_back,
    output logic signed [SAMPLE_WIDTH-1:0]      o_imag_back
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int NS     = rtp_pkg::CORDIC_STEPS;
    localparam int NI     = (NS > SW) ? NS : SW;
    localparam int VW     = rtp_pkg::VEC_WIDTH;
    localparam int ZW     = rtp_pkg::ZW;
    localparam int VSHIFT = VW - 3 - SW;
    localparam int AW     = 9 + ANGLE_FRAC_BITS;
    localparam int RSH    = rtp_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int PW     = SW + rtp_pkg::INVK_WIDTH;
    localparam int RW     = SW + 32;
    localparam int OW     = RW - 30;

    localparam logic signed [ZW-1:0] Z90   = ZW'(rtp_pkg::DEG90_INT * (64'sd1 <<< rtp_pkg::ZFRAC));
    localparam logic signed [ZW-1:0] ZHALF = ZW'(64'sd1 <<< (RSH - 1));
    localparam logic signed [AW-1:0] DEG90  = AW'(rtp_pkg::DEG90_INT * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] DEG180 = AW'(rtp_pkg::DEG180_INT * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [RW-1:0] RHALF  = RW'(64'sd1 <<< 29);
    localparam logic signed [OW-1:0] SAT_HI = OW'((64'sd1 <<< (SW - 1)) - 1);
    localparam logic signed [OW-1:0] SAT_LO = OW'(-(64'sd1 <<< (SW - 1)));

    logic en;

    // stage A: squares and scaled CORDIC start
    logic                  r_a_v;
    logic [2*SW-1:0]       r_a_sqx;
    logic [2*SW-1:0]       r_a_sqy;
    logic signed [VW-1:0]  r_a_vx;
    logic signed [VW-1:0]  r_a_vy;
    rtp_pkg::t_cls         r_a_cls;

    // iteration stages: square root digits and vectoring steps in lockstep
    logic                  r_it_v    [NI+1];
    logic [2*SW-1:0]       r_it_s    [NI+1];
    logic [SW+1:0]         r_it_rem  [NI+1];
    logic [SW-1:0]         r_it_root [NI+1];
    logic signed [VW-1:0]  r_it_x    [NI+1];
    logic signed [VW-1:0]  r_it_y    [NI+1];
    logic signed [ZW-1:0]  r_it_z    [NI+1];
    rtp_pkg::t_cls         r_it_cls  [NI+1];

    // stage C: rounded magnitude and mapped angle
    logic                  r_c_v;
    logic [SW-1:0]         r_c_mag;
    logic signed [AW-1:0]  r_c_ang;
    logic [1:0]            r_c_quad;
    logic [SW-1:0]         n_c_mag;
    logic signed [AW-1:0]  n_c_ang;
    logic signed [ZW-1:0]  zc;
    logic signed [ZW-1:0]  zr;
    logic signed [AW-1:0]  a1;

    // stage D: scaled magnitude and folded angle
    logic                  r_d_v;
    logic [PW-1:0]         r_d_prod;
    logic                  r_d_neg;
    logic signed [ZW-1:0]  r_d_z;
    logic [SW-1:0]         r_d_mag;
    logic signed [AW-1:0]  r_d_ang;
    logic [1:0]            r_d_quad;
    logic                  n_d_neg;
    logic signed [AW-1:0]  n_d_angf;

    // rotation stages
    logic                  r_rt_v    [NS+1];
    logic signed [RW-1:0]  r_rt_x    [NS+1];
    logic signed [RW-1:0]  r_rt_y    [NS+1];
    logic signed [ZW-1:0]  r_rt_z    [NS+1];
    logic [SW-1:0]         r_rt_mag  [NS+1];
    logic signed [AW-1:0]  r_rt_ang  [NS+1];
    logic [1:0]            r_rt_quad [NS+1];

    // output register
    logic                  r_out_v;
    logic [SW-1:0]         r_out_mag;
    logic signed [AW-1:0]  r_out_ang;
    logic [1:0]            r_out_quad;
    logic signed [SW-1:0]  r_out_re;
    logic signed [SW-1:0]  r_out_im;
    logic signed [RW-1:0]  rx_full;
    logic signed [RW-1:0]  ry_full;
    logic signed [OW-1:0]  rx_t;
    logic signed [OW-1:0]  ry_t;
    logic signed [SW-1:0]  n_out_re;
    logic signed [SW-1:0]  n_out_im;

    // advance the whole pipeline unless a finished result is held
    assign en         = !r_out_v || !i_stall;
    assign o_fifo_pop = i_fifo_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= o_fifo_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sqx <= {{SW{1'b0}}, i_ax} * {{SW{1'b0}}, i_ax};
            r_a_sqy <= {{SW{1'b0}}, i_ay} * {{SW{1'b0}}, i_ay};
            r_a_vx  <= VW'(i_ax) << VSHIFT;
            r_a_vy  <= VW'(i_ay) << VSHIFT;
            r_a_cls <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_v[0] <= 1'b0;
        end else if (en) begin
            r_it_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it_s[0]    <= r_a_sqx + r_a_sqy;
            r_it_rem[0]  <= '0;
            r_it_root[0] <= '0;
            r_it_x[0]    <= r_a_vx;
            r_it_y[0]    <= r_a_vy;
            r_it_z[0]    <= '0;
            r_it_cls[0]  <= r_a_cls;
        end
    end

    for (genvar gi = 0; gi < NI; gi++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_v[gi+1] <= 1'b0;
            end else if (en) begin
                r_it_v[gi+1] <= r_it_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_it_s[gi+1]   <= r_it_s[gi];
                r_it_cls[gi+1] <= r_it_cls[gi];
            end
        end

        if (gi < SW) begin : g_sq
            logic [SW+1:0] pre;
            logic [SW+1:0] trial;
            assign pre   = {r_it_rem[gi][SW-1:0], r_it_s[gi][2*SW-1-2*gi -: 2]};
            assign trial = {r_it_root[gi], 2'b01};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (pre >= trial) begin
                        r_it_rem[gi+1]  <= pre - trial;
                        r_it_root[gi+1] <= {r_it_root[gi][SW-2:0], 1'b1};
                    end else begin
                        r_it_rem[gi+1]  <= pre;
                        r_it_root[gi+1] <= {r_it_root[gi][SW-2:0], 1'b0};
                    end
                end
            end
        end else begin : g_sq_hold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_it_rem[gi+1]  <= r_it_rem[gi];
                    r_it_root[gi+1] <= r_it_root[gi];
                end
            end
        end

        if (gi < NS) begin : g_vec
            logic signed [VW-1:0] dx;
            logic signed [VW-1:0] dy;
            assign dx = r_it_y[gi] >>> gi;
            assign dy = r_it_x[gi] >>> gi;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_it_y[gi][VW-1]) begin
                        r_it_x[gi+1] <= r_it_x[gi] + dx;
                        r_it_y[gi+1] <= r_it_y[gi] - dy;
                        r_it_z[gi+1] <= r_it_z[gi] + rtp_pkg::ATAN_TAB[gi];
                    end else begin
                        r_it_x[gi+1] <= r_it_x[gi] - dx;
                        r_it_y[gi+1] <= r_it_y[gi] + dy;
                        r_it_z[gi+1] <= r_it_z[gi] - rtp_pkg::ATAN_TAB[gi];
                    end
                end
            end
        end else begin : g_vec_hold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_it_x[gi+1] <= r_it_x[gi];
                    r_it_y[gi+1] <= r_it_y[gi];
                    r_it_z[gi+1] <= r_it_z[gi];
                end
            end
        end
    end

    // clamp to [0,90], round to angle units, map to the quadrant
    always_comb begin
        n_c_mag = (r_it_rem[NI] > {2'b00, r_it_root[NI]}) ? r_it_root[NI] + 1'b1
                                                          : r_it_root[NI];
        if (r_it_z[NI] < 0) begin
            zc = '0;
        end else if (r_it_z[NI] > Z90) begin
            zc = Z90;
        end else begin
            zc = r_it_z[NI];
        end
        zr = (zc + ZHALF) >>> RSH;
        if (r_it_cls[NI].ay_zero) begin
            a1 = '0;
        end else if (r_it_cls[NI].ax_zero) begin
            a1 = DEG90;
        end else begin
            a1 = AW'(zr);
        end
        case (r_it_cls[NI].quad)
            rtp_pkg::QUAD_FIRST:  n_c_ang = a1;
            rtp_pkg::QUAD_SECOND: n_c_ang = DEG180 - a1;
            rtp_pkg::QUAD_THIRD:  n_c_ang = (a1 == '0) ? DEG180 : a1 - DEG180;
            default:              n_c_ang = -a1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_it_v[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_mag  <= n_c_mag;
            r_c_ang  <= n_c_ang;
            r_c_quad <= r_it_cls[NI].quad;
        end
    end

    // fold angles beyond +/-90 onto the right half plane with a negated start
    always_comb begin
        n_d_neg  = 1'b0;
        n_d_angf = r_c_ang;
        if (r_c_ang > DEG90) begin
            n_d_neg  = 1'b1;
            n_d_angf = r_c_ang - DEG180;
        end else if (r_c_ang < -DEG90) begin
            n_d_neg  = 1'b1;
            n_d_angf = r_c_ang + DEG180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_prod <= PW'(r_c_mag) * PW'(rtp_pkg::INVK_Q30);
            r_d_neg  <= n_d_neg;
            r_d_z    <= ZW'(n_d_angf) <<< RSH;
            r_d_mag  <= r_c_mag;
            r_d_ang  <= r_c_ang;
            r_d_quad <= r_c_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_v[0] <= 1'b0;
        end else if (en) begin
            r_rt_v[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt_x[0]    <= r_d_neg ? -RW'(r_d_prod) : RW'(r_d_prod);
            r_rt_y[0]    <= '0;
            r_rt_z[0]    <= r_d_z;
            r_rt_mag[0]  <= r_d_mag;
            r_rt_ang[0]  <= r_d_ang;
            r_rt_quad[0] <= r_d_quad;
        end
    end

    for (genvar gk = 0; gk < NS; gk++) begin : g_rot
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        assign dx = r_rt_y[gk] >>> gk;
        assign dy = r_rt_x[gk] >>> gk;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[gk+1] <= 1'b0;
            end else if (en) begin
                r_rt_v[gk+1] <= r_rt_v[gk];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_rt_z[gk][ZW-1]) begin
                    r_rt_x[gk+1] <= r_rt_x[gk] - dx;
                    r_rt_y[gk+1] <= r_rt_y[gk] + dy;
                    r_rt_z[gk+1] <= r_rt_z[gk] - rtp_pkg::ATAN_TAB[gk];
                end else begin
                    r_rt_x[gk+1] <= r_rt_x[gk] + dx;
                    r_rt_y[gk+1] <= r_rt_y[gk] - dy;
                    r_rt_z[gk+1] <= r_rt_z[gk] + rtp_pkg::ATAN_TAB[gk];
                end
                r_rt_mag[gk+1]  <= r_rt_mag[gk];
                r_rt_ang[gk+1]  <= r_rt_ang[gk];
                r_rt_quad[gk+1] <= r_rt_quad[gk];
            end
        end
    end

    // round half up from Q30, then saturate to the sample range
    always_comb begin
        rx_full = (r_rt_x[NS] + RHALF) >>> 30;
        ry_full = (r_rt_y[NS] + RHALF) >>> 30;
        rx_t    = OW'(rx_full);
        ry_t    = OW'(ry_full);
        if (rx_t > SAT_HI) begin
            n_out_re = SW'(SAT_HI);
        end else if (rx_t < SAT_LO) begin
            n_out_re = SW'(SAT_LO);
        end else begin
            n_out_re = SW'(rx_t);
        end
        if (ry_t > SAT_HI) begin
            n_out_im = SW'(SAT_HI);
        end else if (ry_t < SAT_LO) begin
            n_out_im = SW'(SAT_LO);
        end else begin
            n_out_im = SW'(ry_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_rt_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_mag  <= r_rt_mag[NS];
            r_out_ang  <= r_rt_ang[NS];
            r_out_quad <= r_rt_quad[NS];
            r_out_re   <= n_out_re;
            r_out_im   <= n_out_im;
        end
    end

    assign o_valid     = r_out_v;
    assign o_magnitude = r_out_mag;
    assign o_angle_deg = r_out_ang;
    assign o_quadrant  = r_out_quad;
    assign o_real_back = r_out_re;
    assign o_imag_back = r_out_im;

endmodule

// File: rtl/rect_to_polar_round_trip.sv
// Top level: rectangular to polar conversion with rebuild to rectangular parts.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  input   | i_valid / o_stall    | i_real_in, i_imag_in
//  output  | o_valid / i_stall    | o_magnitude, o_angle_deg, o_quadrant,
//          |                      | o_real_back, o_imag_back
//
// One transaction per clock in steady state while i_stall is low. o_valid rises once the
// input transaction has passed through the front register, the queue and the back
// pipeline; the two 28-step CORDIC chains and the square root digit chain set its depth.
// Synchronous active-low reset empties the queue and all pipeline valid bits.
// Output stall freezes the back pipeline; the 4-entry queue then fills before
// o_stall rises.
module rect_to_polar_round_trip #(
    parameter int SAMPLE_WIDTH    = rtp_pkg::SAMPLE_WIDTH,
    parameter int ANGLE_FRAC_BITS = rtp_pkg::ANGLE_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_real_in,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_imag_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [SAMPLE_WIDTH-1:0]           o_magnitude,
    output logic signed [8+ANGLE_FRAC_BITS:0] o_angle_deg,
    output logic [1:0]                        o_quadrant,
    output logic signed [SAMPLE_WIDTH-1:0]    o_real_back,
    output logic signed [SAMPLE_WIDTH-1:0]    o_imag_back
);

    localparam int CW = $bits(rtp_pkg::t_cls);
    localparam int QW = CW + 2 * SAMPLE_WIDTH;

    logic                    push;
    logic                    full;
    logic                    pop;
    logic                    q_valid;
    logic [SAMPLE_WIDTH-1:0] f_ax;
    logic [SAMPLE_WIDTH-1:0] f_ay;
    rtp_pkg::t_cls           f_cls;
    logic [QW-1:0]           q_in;
    logic [QW-1:0]           q_out;
    rtp_pkg::t_cls           b_cls;

    rtp_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_real_in (i_real_in),
        .i_imag_in (i_imag_in),
        .i_full    (full),
        .o_push    (push),
        .o_ax      (f_ax),
        .o_ay      (f_ay),
        .o_cls     (f_cls)
    );

    assign q_in  = {f_cls, f_ax, f_ay};
    assign b_cls = q_out[QW-1 -: CW];

    rtp_fifo #(
        .WIDTH(QW),
        .DEPTH(rtp_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    rtp_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (q_valid),
        .o_fifo_pop   (pop),
        .i_ax         (q_out[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_ay         (q_out[SAMPLE_WIDTH-1:0]),
        .i_cls        (b_cls),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_magnitude  (o_magnitude),
        .o_angle_deg  (o_angle_deg),
        .o_quadrant   (o_quadrant),
        .o_real_back  (o_real_back),
        .o_imag_back  (o_imag_back)
    );

endmodule
